// File: hw/rtl/fscc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command codes and the word type passed along the cell chain.
package fscc_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int COUNT_BITS  = 32;
	localparam int CHAR_W      = 8;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
	localparam int OUT_COUNT_W = 32;
	localparam int OUT_USED_W  = 9;

	localparam logic [CHAR_W-1:0]     PRINT_LIMIT = 8'd31;
	localparam logic [CHAR_W-1:0]     NEWLINE     = 8'd10;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;

	typedef enum logic {
		CMD_COUNT = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                  vld;
		cmd_t                  cmd;
		logic [CHAR_W-1:0]     byte_value;
		logic [7:0]            slot_index;
		logic                  acc;
		logic                  done;
		logic                  is_new;
		logic [7:0]            slot;
		logic [CHAR_W-1:0]     chr;
		logic [COUNT_BITS-1:0] cnt;
		logic                  svalid;
		logic [USED_W-1:0]     used;
	} item_t;

endpackage

// File: hw/rtl/fscc_cell.sv
`timescale 1ns / 1ps
// One table entry: holds a character and its count, updates it and forwards the word.
module fscc_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic [fscc_pkg::SLOT_W-1:0]  cell_index,
	input  fscc_pkg::item_t              item_in,
	output fscc_pkg::item_t              item_out
);
	import fscc_pkg::*;

	logic                  valid_q;
	logic [CHAR_W-1:0]     char_q;
	logic [COUNT_BITS-1:0] cnt_q;
	item_t                 fwd_s1;
	item_t                 nxt;
	logic                  seek;
	logic                  hit;
	logic                  app;
	logic                  rd;
	logic [COUNT_BITS-1:0] cnt_next;

	always_comb begin
		seek     = item_in.vld && (item_in.cmd == CMD_COUNT) && item_in.acc && !item_in.done;
		hit      = seek && valid_q && (char_q == item_in.byte_value);
		app      = seek && !valid_q;
		rd       = item_in.vld && (item_in.cmd == CMD_READ)
			&& (item_in.slot_index == 8'(cell_index));
		cnt_next = hit ? ((cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_BITS'(1))
			: COUNT_BITS'(1);
		nxt = item_in;
		if (hit || app) begin
			nxt.done   = 1'b1;
			nxt.is_new = app;
			nxt.slot   = 8'(cell_index);
			nxt.chr    = item_in.byte_value;
			nxt.cnt    = cnt_next;
			nxt.svalid = 1'b1;
		end
		if (rd) begin
			nxt.chr    = valid_q ? char_q : '0;
			nxt.cnt    = valid_q ? cnt_q : '0;
			nxt.svalid = valid_q;
		end
		nxt.used = item_in.used + USED_W'(valid_q || app);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			fwd_s1  <= '0;
		end else if (adv) begin
			if (app) begin
				valid_q <= 1'b1;
			end
			fwd_s1 <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (hit || app)) begin
			char_q <= item_in.byte_value;
			cnt_q  <= cnt_next;
		end
	end

	assign item_out = fwd_s1;

endmodule

// File: hw/rtl/first_seen_char_counter.sv
`timescale 1ns / 1ps
// An accepted word is registered in each cell of the chain in turn before it appears as the result word.
// Throughput: one word per cycle; the whole cell chain holds while a result waits unread.
// Each word sees the table as left by every earlier word, so words may follow back to back.
// Reset: asynchronous, active low; clears every entry's used flag, leaving an empty table.
// Entry characters and counts are not cleared; they are written before they are read.
// Top level: character frequency table kept in order of first appearance.
module first_seen_char_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        cmd,
	input  logic [7:0]  byte_value,
	input  logic [7:0]  slot_index,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        accepted,
	output logic        is_new,
	output logic        table_full,
	output logic [7:0]  slot,
	output logic [7:0]  char_out,
	output logic [31:0] count_out,
	output logic        slot_valid,
	output logic [8:0]  used_out
);
	import fscc_pkg::*;

	item_t chain [TABLE_DEPTH+1];
	item_t head;
	item_t last;
	logic  adv;
	logic  pass;
	logic  full;

	assign last       = chain[TABLE_DEPTH];
	assign adv        = !last.vld || result_ready;
	assign item_ready = adv;

	always_comb begin
		pass = (cmd_t'(cmd) == CMD_COUNT)
			&& ((byte_value > PRINT_LIMIT) || (byte_value == NEWLINE));
		head            = '0;
		head.vld        = item_valid;
		head.cmd        = cmd_t'(cmd);
		head.byte_value = byte_value;
		head.slot_index = slot_index;
		head.acc        = pass;
		head.slot       = (cmd_t'(cmd) == CMD_READ) ? slot_index : 8'd0;
	end

	assign chain[0] = head;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		fscc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.cell_index (SLOT_W'(g)),
			.item_in    (chain[g]),
			.item_out   (chain[g+1])
		);
	end

	assign full         = last.acc && !last.done;
	assign result_valid = last.vld;
	assign accepted     = last.acc;
	assign is_new       = last.is_new;
	assign table_full   = full;
	assign slot         = last.slot;
	assign char_out     = full ? last.byte_value : last.chr;
	assign count_out    = OUT_COUNT_W'(last.cnt);
	assign slot_valid   = last.svalid;
	assign used_out     = OUT_USED_W'(last.used);

endmodule

// File: hw/rtl/fscc_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel of the frequency table, bound to the top level.
module fscc_props (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic        accepted,
	input logic        is_new,
	input logic        table_full,
	input logic [7:0]  slot,
	input logic [31:0] count_out,
	input logic        slot_valid,
	input logic [8:0]  used_out
);
	import fscc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(used_out) && $stable(slot))
		else $error("result word changed while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !accepted |-> !is_new && !table_full)
		else $error("append or full flag on an unaccepted word");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && table_full |-> !is_new && !slot_valid
			&& (used_out == OUT_USED_W'(TABLE_DEPTH)))
		else $error("full flag with free room");

	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_new |-> slot_valid && (count_out == 32'd1)
			&& (used_out == (OUT_USED_W'(slot) + 9'd1)))
		else $error("appended entry inconsistent");

endmodule

bind first_seen_char_counter fscc_props u_fscc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.accepted     (accepted),
	.is_new       (is_new),
	.table_full   (table_full),
	.slot         (slot),
	.count_out    (count_out),
	.slot_valid   (slot_valid),
	.used_out     (used_out)
);
